// ----- src/ovp_pkg.sv -----
// Shared widths and pipeline item types for the circle overlap push block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ovp_pkg;
    localparam int CW   = 24;             // coordinate width
    localparam int RW   = CW - 1;         // radius width
    localparam int OW   = CW + 1;         // push component width
    localparam int SQW  = 2 * CW;         // width of a square
    localparam int IW   = $clog2(OW);     // index width for the cell rows

    typedef struct packed {
        logic          hit;
        logic          zero;
        logic          nx;
        logic          ny;
        logic [CW-1:0] mx;
        logic [CW-1:0] my;
        logic [CW-1:0] r;
        logic [SQW-1:0] rem;
        logic [CW-1:0] root;
    } t_root_item;

    typedef struct packed {
        logic          hit;
        logic          zero;
        logic          nx;
        logic          ny;
        logic [CW-1:0] r;
        logic [CW-1:0] l;
        logic [SQW-1:0] remx;
        logic [SQW-1:0] remy;
        logic [OW-1:0] qx;
        logic [OW-1:0] qy;
    } t_div_item;
endpackage
`default_nettype wire

// ----- src/ovp_if.sv -----
// Handshake interfaces for circle pair input and push result output.
// Depends on ovp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ovp_in_if;
    import ovp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic [RW-1:0]        a_radius;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic [RW-1:0]        b_radius;
    modport source (output valid, a_x, a_y, a_radius, b_x, b_y, b_radius, input ready);
    modport sink   (input valid, a_x, a_y, a_radius, b_x, b_y, b_radius, output ready);
endinterface

interface ovp_out_if;
    import ovp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic signed [OW-1:0] push_x;
    logic signed [OW-1:0] push_y;
    modport source (output valid, hit, push_x, push_y, input ready);
    modport sink   (input valid, hit, push_x, push_y, output ready);
endinterface
`default_nettype wire

// ----- src/ovp_sqrt_cell.sv -----
// One root bit of the digit-by-digit integer square root.
// Depends on ovp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ovp_sqrt_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic [ovp_pkg::IW-1:0] i_idx,
    input  wire logic                 i_vld,
    input  wire ovp_pkg::t_root_item  i_item,
    output logic                      o_vld,
    output ovp_pkg::t_root_item       o_item
);
    import ovp_pkg::*;

    logic [SQW:0] w_trial;
    t_root_item   n_item;
    t_root_item   r_item;
    logic         r_vld;

    // trial = 2*root*2^idx + 4^idx
    always_comb begin
        w_trial = ((SQW+1)'(i_item.root) << ({1'b0, i_idx} + 1'b1))
                | ((SQW+1)'(1) << {i_idx, 1'b0});
        n_item = i_item;
        if ({1'b0, i_item.rem} >= w_trial) begin
            n_item.rem  = SQW'({1'b0, i_item.rem} - w_trial);
            n_item.root = i_item.root | (CW'(1) << i_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
endmodule
`default_nettype wire

// ----- src/ovp_div_cell.sv -----
// One quotient bit of restoring division, x and y lanes side by side.
// Depends on ovp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ovp_div_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic [ovp_pkg::IW-1:0] i_idx,
    input  wire logic                 i_vld,
    input  wire ovp_pkg::t_div_item   i_item,
    output logic                      o_vld,
    output ovp_pkg::t_div_item        o_item
);
    import ovp_pkg::*;

    logic [SQW+OW-1:0] w_dvs;
    t_div_item         n_item;
    t_div_item         r_item;
    logic              r_vld;

    always_comb begin
        w_dvs  = (SQW+OW)'(i_item.l) << i_idx;
        n_item = i_item;
        if ((SQW+OW)'(i_item.remx) >= w_dvs) begin
            n_item.remx = SQW'((SQW+OW)'(i_item.remx) - w_dvs);
            n_item.qx   = i_item.qx | (OW'(1) << i_idx);
        end
        if ((SQW+OW)'(i_item.remy) >= w_dvs) begin
            n_item.remy = SQW'((SQW+OW)'(i_item.remy) - w_dvs);
            n_item.qy   = i_item.qy | (OW'(1) << i_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
endmodule
`default_nettype wire

// ----- src/circle_overlap_push.sv -----
// Top level of the circle overlap push block: front end, root and divider rows, output.
// Depends on ovp_pkg, ovp_if, ovp_sqrt_cell and ovp_div_cell.
`timescale 1ns / 1ps
`default_nettype none
// Circle pair overlap test with push vector. One pair is taken per cycle while
// the pipeline advances, and its result passes through 2*CW+6 register stages
// (54 at CW = 24): the center difference, the three squares, the overlap
// compare, CW cells of the square root row (one root bit per cell), the two
// products |d|*(r-l), CW+1 cells of the divider row (one quotient bit per
// cell) and the rounding/output register. The whole pipeline advances as one
// unit: it moves whenever the output register is empty or its result is being
// transferred, so input ready follows output ready within the same cycle.
// On a hit the push is |d|*(r-l)/l rounded to nearest, ties away from zero,
// with the sign of d; coincident centers give (0, r); a miss gives zero.
module circle_overlap_push (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ovp_in_if.sink    i_pair,
    ovp_out_if.source o_push
);
    import ovp_pkg::*;

    logic w_adv;

    // stage 1: differences and magnitudes
    logic          r_v1, r_nx1, r_ny1, r_far1;
    logic [CW-1:0] r_mx1, r_my1, r_r1;
    logic          n_nx1, n_ny1, n_far1;
    logic [CW-1:0] n_mx1, n_my1, n_r1;
    logic signed [CW:0] w_dx, w_dy;

    // stage 2: squares
    logic           r_v2, r_nx2, r_ny2, r_far2;
    logic [CW-1:0]  r_mx2, r_my2, r_r2;
    logic [SQW-1:0] r_sqx, r_sqy, r_sqr;

    // stage 3: overlap decision, feeds the root row
    logic       r_v3;
    t_root_item r_it3;
    t_root_item n_it3;
    logic [SQW:0] w_d2;

    logic       w_rv [CW+1];
    t_root_item w_ri [CW+1];

    // product stage, feeds the divider row
    logic      r_vm;
    t_div_item r_itm;
    t_div_item n_itm;
    logic [CW-1:0] w_gap;

    logic      w_dv [OW+1];
    t_div_item w_di [OW+1];

    // output register
    logic                 r_out_vld;
    logic                 r_hit;
    logic signed [OW-1:0] r_px, r_py;
    logic                 n_hit;
    logic signed [OW-1:0] n_px, n_py;
    logic [OW-1:0]        w_qx, w_qy;
    t_div_item            w_last;

    assign w_adv        = !r_out_vld || o_push.ready;
    assign i_pair.ready = w_adv;

    always_comb begin
        w_dx   = (CW+1)'(i_pair.b_x) - (CW+1)'(i_pair.a_x);
        w_dy   = (CW+1)'(i_pair.b_y) - (CW+1)'(i_pair.a_y);
        n_nx1  = w_dx[CW];
        n_ny1  = w_dy[CW];
        n_mx1  = n_nx1 ? CW'(-w_dx) : CW'(w_dx);
        n_my1  = n_ny1 ? CW'(-w_dy) : CW'(w_dy);
        n_r1   = CW'(i_pair.a_radius) + CW'(i_pair.b_radius);
        // a component at least r long can never overlap
        n_far1 = (n_mx1 >= n_r1) || (n_my1 >= n_r1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vm <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_pair.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vm <= w_rv[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nx1  <= n_nx1;
            r_ny1  <= n_ny1;
            r_mx1  <= n_mx1;
            r_my1  <= n_my1;
            r_r1   <= n_r1;
            r_far1 <= n_far1;
            r_nx2  <= r_nx1;
            r_ny2  <= r_ny1;
            r_mx2  <= r_mx1;
            r_my2  <= r_my1;
            r_r2   <= r_r1;
            r_far2 <= r_far1;
            r_sqx  <= r_mx1 * r_mx1;
            r_sqy  <= r_my1 * r_my1;
            r_sqr  <= r_r1 * r_r1;
            r_it3  <= n_it3;
            r_itm  <= n_itm;
        end
    end

    always_comb begin
        w_d2       = (SQW+1)'(r_sqx) + (SQW+1)'(r_sqy);
        n_it3.hit  = !r_far2 && (w_d2 < (SQW+1)'(r_sqr));
        n_it3.zero = (w_d2 == '0);
        n_it3.nx   = r_nx2;
        n_it3.ny   = r_ny2;
        n_it3.mx   = r_mx2;
        n_it3.my   = r_my2;
        n_it3.r    = r_r2;
        n_it3.rem  = SQW'(w_d2);
        n_it3.root = '0;
    end

    assign w_rv[0] = r_v3;
    assign w_ri[0] = r_it3;

    for (genvar k = 0; k < CW; k++) begin : g_root
        ovp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_idx   (IW'(CW - 1 - k)),
            .i_vld   (w_rv[k]),
            .i_item  (w_ri[k]),
            .o_vld   (w_rv[k+1]),
            .o_item  (w_ri[k+1])
        );
    end

    always_comb begin
        w_gap      = w_ri[CW].r - w_ri[CW].root;
        n_itm.hit  = w_ri[CW].hit;
        n_itm.zero = w_ri[CW].zero;
        n_itm.nx   = w_ri[CW].nx;
        n_itm.ny   = w_ri[CW].ny;
        n_itm.r    = w_ri[CW].r;
        n_itm.l    = w_ri[CW].root;
        n_itm.remx = w_ri[CW].mx * w_gap;
        n_itm.remy = w_ri[CW].my * w_gap;
        n_itm.qx   = '0;
        n_itm.qy   = '0;
    end

    assign w_dv[0] = r_vm;
    assign w_di[0] = r_itm;

    // quotient never exceeds r - l, so OW bits cover it
    for (genvar k = 0; k < OW; k++) begin : g_div
        ovp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_idx   (IW'(OW - 1 - k)),
            .i_vld   (w_dv[k]),
            .i_item  (w_di[k]),
            .o_vld   (w_dv[k+1]),
            .o_item  (w_di[k+1])
        );
    end

    // round to nearest, ties away from zero, then apply signs and special cases
    always_comb begin
        w_last = w_di[OW];
        w_qx   = w_last.qx;
        w_qy   = w_last.qy;
        if ((SQW+1)'(w_last.remx) >= (SQW+1)'(w_last.l) - (SQW+1)'(w_last.remx)) begin
            w_qx = w_qx + 1'b1;
        end
        if ((SQW+1)'(w_last.remy) >= (SQW+1)'(w_last.l) - (SQW+1)'(w_last.remy)) begin
            w_qy = w_qy + 1'b1;
        end
        n_hit = w_last.hit;
        n_px  = '0;
        n_py  = '0;
        if (w_last.hit) begin
            if (w_last.zero) begin
                n_py = OW'(w_last.r);
            end else begin
                n_px = w_last.nx ? -w_qx : w_qx;
                n_py = w_last.ny ? -w_qy : w_qy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_dv[OW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit <= n_hit;
            r_px  <= n_px;
            r_py  <= n_py;
        end
    end

    assign o_push.valid  = r_out_vld;
    assign o_push.hit    = r_hit;
    assign o_push.push_x = r_px;
    assign o_push.push_y = r_py;
endmodule
`default_nettype wire

// ----- src/ovp_checker.sv -----
// Port level checks for circle_overlap_push, attached by bind.
// Depends on ovp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module ovp_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic                       i_hit,
    input wire logic [ovp_pkg::OW-1:0]     i_push_x,
    input wire logic [ovp_pkg::OW-1:0]     i_push_y
);
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> i_push_x == '0 && i_push_y == '0)
        else $error("miss with nonzero push");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready out of step with output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_push_x) && $stable(i_push_y))
        else $error("stalled result changed");
endmodule

bind circle_overlap_push ovp_checker u_ovp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_push.valid),
    .i_out_ready (o_push.ready),
    .i_hit       (o_push.hit),
    .i_push_x    (o_push.push_x),
    .i_push_y    (o_push.push_y)
);
`default_nettype wire
